FILE: rtl/thsh_pkg.sv
// Shared types, widths and constants for the terrain texel shader.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package thsh_pkg;

    // Field and datapath widths
    localparam int H_W     = 8;           // raw height sample
    localparam int S_W     = 16;          // Q8.8 spacing and scale
    localparam int COL_W   = 32;          // ARGB color word
    localparam int CH_W    = 8;           // one color channel
    localparam int NUM_CH  = COL_W / CH_W;
    localparam int KD_W    = S_W + H_W;   // scale * |height difference|
    localparam int SQ_W    = 2 * S_W;     // spacing squared
    localparam int KD2_W   = 2 * KD_W;    // (scale * diff) squared
    localparam int D_W     = KD2_W + 2;   // sum of the three squares
    localparam int Q_W     = SQ_W + 1;    // quotient, at most 2^32
    localparam int R_W     = Q_W + 1;     // square root work width
    localparam int C_W     = 16;          // Q0.16 cosine
    localparam int ROOT_STEPS = (Q_W + 1) / 2;
    localparam int NUM_BANDS  = 6;

    // Register indexes on the config port
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_CELL_SPACING = 3'd0;
    localparam t_reg_idx REG_HEIGHT_SCALE = 3'd1;
    localparam t_reg_idx REG_COLOR_BAND0  = 3'd2;

    // Register reset values
    localparam logic [S_W-1:0]   SPACING_RST = 16'd256;
    localparam logic [S_W-1:0]   SCALE_RST   = 16'd256;
    localparam logic [COL_W-1:0] BAND_RST    = 32'h0000_0000;
    localparam logic [COL_W-1:0] TOP_BAND_RST = 32'hFFFF_FFFF;

    // Height band limits (exclusive upper bounds)
    localparam logic [H_W-1:0] BAND_LIM0 = 8'd43;
    localparam logic [H_W-1:0] BAND_LIM1 = 8'd85;
    localparam logic [H_W-1:0] BAND_LIM2 = 8'd128;
    localparam logic [H_W-1:0] BAND_LIM3 = 8'd170;
    localparam logic [H_W-1:0] BAND_LIM4 = 8'd213;

    localparam logic [C_W-1:0]  COS_MAX   = 16'hFFFF;
    localparam logic [KD_W-1:0] ROUND_HALF = 24'd32768;

    typedef logic [2:0] t_band;
    typedef logic [NUM_BANDS-1:0][COL_W-1:0] t_band_colors;

    // Configuration register file contents
    typedef struct packed {
        logic [S_W-1:0] spacing;
        logic [S_W-1:0] scale;
        t_band_colors   band_color;
    } t_cfg;

    // Side information that travels with each word down the pipeline
    typedef struct packed {
        logic  zero;    // spacing is zero: cosine forced to zero
        t_band band;
    } t_side;

    // Pick the color band from the raw height
    function automatic t_band band_of(input logic [H_W-1:0] h);
        t_band b;
        if (h < BAND_LIM0)      b = 3'd0;
        else if (h < BAND_LIM1) b = 3'd1;
        else if (h < BAND_LIM2) b = 3'd2;
        else if (h < BAND_LIM3) b = 3'd3;
        else if (h < BAND_LIM4) b = 3'd4;
        else                    b = 3'd5;
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/terrain_height_shade_texel.sv
// Terrain texel shader: band color from height, lit by the normal cosine.
// Pipeline: 4 front stages, a 33-stage divider, a 17-stage square root, 2 shading
// stages and the output register. A skid register keeps input open while one result
// waits; throughput is one word per cycle while the skid register is empty.
// Synchronous active-low reset clears valid bits and restores config defaults.
`default_nettype none

module terrain_height_shade_texel
    import thsh_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // input stream
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [23:0]      i_s_axis_tdata,   // height_here, height_right, height_below
    // result stream
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic [COL_W-1:0]      o_m_axis_tdata,   // texel_color
    // config write port
    input  wire logic             i_cfg_we,
    input  wire t_reg_idx         i_cfg_idx,
    input  wire logic [COL_W-1:0] i_cfg_data
);

    t_cfg             w_cfg;
    logic             w_en;
    logic             w_f_v, w_d_v, w_r_v, w_s_v;
    t_side            w_f_side, w_d_side, w_r_side;
    logic [SQ_W-1:0]  w_f_s2;
    logic [D_W-1:0]   w_f_d;
    logic [Q_W-1:0]   w_quo;
    logic [R_W-1:0]   w_root;
    logic [COL_W-1:0] w_texel;
    logic             w_push;
    logic             r_out_valid, r_skid_valid;
    logic [COL_W-1:0] r_out_data, r_skid_data;

    // whole pipeline moves unless the skid register is holding a word
    assign w_en            = ~r_skid_valid;
    assign o_s_axis_tready = w_en;
    assign w_push          = w_en & w_s_v;

    thsh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    thsh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_axis_tvalid),
        .i_here    (i_s_axis_tdata[7:0]),
        .i_right   (i_s_axis_tdata[15:8]),
        .i_below   (i_s_axis_tdata[23:16]),
        .i_spacing (w_cfg.spacing),
        .i_scale   (w_cfg.scale),
        .o_valid   (w_f_v),
        .o_side    (w_f_side),
        .o_s2      (w_f_s2),
        .o_d       (w_f_d)
    );

    thsh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_side  (w_f_side),
        .i_s2    (w_f_s2),
        .i_d     (w_f_d),
        .o_valid (w_d_v),
        .o_side  (w_d_side),
        .o_quo   (w_quo)
    );

    thsh_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_v),
        .i_side  (w_d_side),
        .i_quo   (w_quo),
        .o_valid (w_r_v),
        .o_side  (w_r_side),
        .o_root  (w_root)
    );

    thsh_shade u_shade (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_r_v),
        .i_side   (w_r_side),
        .i_root   (w_root),
        .i_colors (w_cfg.band_color),
        .o_valid  (w_s_v),
        .o_texel  (w_texel)
    );

    // output register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (~r_out_valid | i_m_axis_tready) begin
            r_out_valid <= w_push;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (~r_out_valid | i_m_axis_tready) begin
            if (w_push) begin
                r_out_data <= w_texel;
            end
        end else if (w_push) begin
            r_skid_data <= w_texel;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/thsh_cfg.sv
// Configuration register file: spacing, height scale and six band colors.
// Depends on thsh_pkg.
`default_nettype none

module thsh_cfg
    import thsh_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire t_reg_idx         i_idx,
    input  wire logic [COL_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_band_sel;

    // band registers sit at consecutive indexes after the scale
    assign w_band_sel = i_idx - REG_COLOR_BAND0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing    <= SPACING_RST;
            r_cfg.scale      <= SCALE_RST;
            r_cfg.band_color <= {TOP_BAND_RST, {(NUM_BANDS-1){BAND_RST}}};
        end else if (i_we) begin
            case (i_idx)
                REG_CELL_SPACING: begin
                    r_cfg.spacing <= i_data[S_W-1:0];
                end
                REG_HEIGHT_SCALE: begin
                    r_cfg.scale <= i_data[S_W-1:0];
                end
                default: begin
                    r_cfg.band_color[w_band_sel] <= i_data;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/thsh_front.sv
// Front end: band select, height differences and the squared-length sum.
// Four register stages of subtract, multiply and add. Depends on thsh_pkg.
`default_nettype none

module thsh_front
    import thsh_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [H_W-1:0]  i_here,
    input  wire logic [H_W-1:0]  i_right,
    input  wire logic [H_W-1:0]  i_below,
    input  wire logic [S_W-1:0]  i_spacing,
    input  wire logic [S_W-1:0]  i_scale,
    output logic                 o_valid,
    output t_side                o_side,
    output logic [SQ_W-1:0]      o_s2,
    output logic [D_W-1:0]       o_d
);

    logic             r1_v, r2_v, r3_v, r4_v;
    t_side            r1_side, r2_side, r3_side, r4_side;
    logic [H_W-1:0]   r1_ab, r1_ac;
    logic [KD_W-1:0]  r2_kb, r2_kc;
    logic [SQ_W-1:0]  r2_s2, r3_s2, r4_s2;
    logic [KD2_W-1:0] r3_kb2, r3_kc2;
    logic [D_W-1:0]   r4_d;
    t_side            w_side;

    assign w_side.zero = (i_spacing == '0);
    assign w_side.band = band_of(i_here);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: absolute height differences
            r1_side <= w_side;
            r1_ab   <= (i_right >= i_here) ? i_right - i_here : i_here - i_right;
            r1_ac   <= (i_below >= i_here) ? i_below - i_here : i_here - i_below;
            // stage 2: scale the differences, square the spacing
            r2_side <= r1_side;
            r2_kb   <= KD_W'(i_scale) * KD_W'(r1_ab);
            r2_kc   <= KD_W'(i_scale) * KD_W'(r1_ac);
            r2_s2   <= SQ_W'(i_spacing) * SQ_W'(i_spacing);
            // stage 3: square the scaled differences
            r3_side <= r2_side;
            r3_kb2  <= KD2_W'(r2_kb) * KD2_W'(r2_kb);
            r3_kc2  <= KD2_W'(r2_kc) * KD2_W'(r2_kc);
            r3_s2   <= r2_s2;
            // stage 4: squared length of the normal
            r4_side <= r3_side;
            r4_d    <= D_W'(r3_s2) + D_W'(r3_kb2) + D_W'(r3_kc2);
            r4_s2   <= r3_s2;
        end
    end

    assign o_valid = r4_v;
    assign o_side  = r4_side;
    assign o_s2    = r4_s2;
    assign o_d     = r4_d;

endmodule

`default_nettype wire

FILE: rtl/thsh_div.sv
// Pipelined restoring divider: (s^2 << 32) / d, one quotient bit per stage.
// When d is nonzero the quotient never exceeds 2^32, since d >= s^2. Depends on thsh_pkg.
`default_nettype none

module thsh_div
    import thsh_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire t_side           i_side,
    input  wire logic [SQ_W-1:0] i_s2,
    input  wire logic [D_W-1:0]  i_d,
    output logic                 o_valid,
    output t_side                o_side,
    output logic [Q_W-1:0]       o_quo
);

    logic           w_v    [Q_W+1];
    t_side          w_side [Q_W+1];
    logic [Q_W-1:0] w_quo  [Q_W+1];
    logic [D_W-1:0] w_rem  [Q_W];
    logic [D_W-1:0] w_dvs  [Q_W];

    // dividend bits above the quotient width start as the remainder
    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;
    assign w_quo[0]  = '0;
    assign w_rem[0]  = D_W'(i_s2[SQ_W-1:1]);
    assign w_dvs[0]  = i_d;

    genvar j;
    generate
        for (j = 0; j < Q_W; j++) begin : g_step
            logic           w_in;
            logic [D_W:0]   w_trial;
            logic [D_W:0]   w_diff;
            logic           w_ge;
            logic           r_v;
            t_side          r_side;
            logic [Q_W-1:0] r_quo;

            // only the first step shifts in a dividend bit that can be nonzero
            if (j == 0) begin : g_first
                assign w_in = i_s2[0];
            end else begin : g_rest
                assign w_in = 1'b0;
            end

            // remainder < divisor, so the difference fits the sign check
            assign w_trial = {w_rem[j], w_in};
            assign w_diff  = w_trial - {1'b0, w_dvs[j]};
            assign w_ge    = ~w_diff[D_W];

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side <= w_side[j];
                    r_quo  <= {w_quo[j][Q_W-2:0], w_ge};
                end
            end

            assign w_v[j+1]    = r_v;
            assign w_side[j+1] = r_side;
            assign w_quo[j+1]  = r_quo;

            // remainder and divisor are not needed after the last step
            if (j < Q_W - 1) begin : g_carry
                logic [D_W-1:0] r_rem;
                logic [D_W-1:0] r_dvs;

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
                        r_dvs <= w_dvs[j];
                    end
                end

                assign w_rem[j+1] = r_rem;
                assign w_dvs[j+1] = r_dvs;
            end
        end
    endgenerate

    assign o_valid = w_v[Q_W];
    assign o_side  = w_side[Q_W];
    assign o_quo   = w_quo[Q_W];

endmodule

`default_nettype wire

FILE: rtl/thsh_isqrt.sv
// Pipelined integer square root of the quotient, one root bit per stage.
// Digit-by-digit method with a fixed starting bit. Depends on thsh_pkg.
`default_nettype none

module thsh_isqrt
    import thsh_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire t_side          i_side,
    input  wire logic [Q_W-1:0] i_quo,
    output logic                o_valid,
    output t_side               o_side,
    output logic [R_W-1:0]      o_root
);

    logic           w_v    [ROOT_STEPS+1];
    t_side          w_side [ROOT_STEPS+1];
    logic [R_W-1:0] w_res  [ROOT_STEPS+1];
    logic [R_W-1:0] w_x    [ROOT_STEPS];

    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;
    assign w_res[0]  = '0;
    assign w_x[0]    = R_W'(i_quo);

    genvar j;
    generate
        for (j = 0; j < ROOT_STEPS; j++) begin : g_step
            localparam logic [R_W-1:0] STEP_BIT =
                {{(R_W-1){1'b0}}, 1'b1} << (2 * (ROOT_STEPS - 1 - j));

            logic [R_W-1:0] w_sum;
            logic           w_ge;
            logic           r_v;
            t_side          r_side;
            logic [R_W-1:0] r_res;

            assign w_sum = w_res[j] + STEP_BIT;
            assign w_ge  = (w_x[j] >= w_sum);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v <= 1'b0;
                end else if (i_en) begin
                    r_v <= w_v[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side <= w_side[j];
                    r_res  <= w_ge ? (w_res[j] >> 1) + STEP_BIT : (w_res[j] >> 1);
                end
            end

            assign w_v[j+1]    = r_v;
            assign w_side[j+1] = r_side;
            assign w_res[j+1]  = r_res;

            // the radicand remainder is dead after the last step
            if (j < ROOT_STEPS - 1) begin : g_carry
                logic [R_W-1:0] r_x;

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x <= w_ge ? w_x[j] - w_sum : w_x[j];
                    end
                end

                assign w_x[j+1] = r_x;
            end
        end
    endgenerate

    assign o_valid = w_v[ROOT_STEPS];
    assign o_side  = w_side[ROOT_STEPS];
    assign o_root  = w_res[ROOT_STEPS];

endmodule

`default_nettype wire

FILE: rtl/thsh_shade.sv
// Shading back end: clamp the cosine, fetch the band color, scale channels.
// Two register stages. Depends on thsh_pkg.
`default_nettype none

module thsh_shade
    import thsh_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire t_side          i_side,
    input  wire logic [R_W-1:0] i_root,
    input  wire t_band_colors   i_colors,
    output logic                o_valid,
    output logic [COL_W-1:0]    o_texel
);

    logic             r_a_v, r_b_v;
    logic [C_W-1:0]   r_a_cos;
    logic [COL_W-1:0] r_a_col;
    logic [COL_W-1:0] r_b_texel;
    logic [C_W-1:0]   w_cos;
    logic [COL_W-1:0] w_texel;

    // a flat surface gives a root of exactly one; zero spacing gives zero
    always_comb begin
        if (i_side.zero) begin
            w_cos = '0;
        end else if (i_root > R_W'(COS_MAX)) begin
            w_cos = COS_MAX;
        end else begin
            w_cos = i_root[C_W-1:0];
        end
    end

    // per channel: (ch * cos + half) >> 16, never above 255
    always_comb begin
        logic [KD_W-1:0] prod;
        w_texel = '0;
        for (int n = 0; n < NUM_CH; n++) begin
            prod = KD_W'(r_a_col[n*CH_W +: CH_W]) * KD_W'(r_a_cos) + ROUND_HALF;
            w_texel[n*CH_W +: CH_W] = prod[KD_W-1 -: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_cos   <= w_cos;
            r_a_col   <= i_colors[i_side.band];
            r_b_texel <= w_texel;
        end
    end

    assign o_valid = r_b_v;
    assign o_texel = r_b_texel;

endmodule

`default_nettype wire
